@@ src/vsc_pkg.sv @@
// shared types and constants for the vigenere stream cipher
package vsc_pkg;

    localparam int unsigned ALPHA_N = 26;
    localparam logic [6:0] CHAR_A = 7'd65;
    localparam logic [6:0] CHAR_SPACE = 7'd32;
    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_PTR_W = 2;
    localparam int unsigned Q_CNT_W = 3;

    localparam logic [1:0] MODE_ENC = 2'd0;
    localparam logic [1:0] MODE_DEC = 2'd1;
    localparam logic [1:0] MODE_VAR = 2'd2;
    localparam logic [1:0] MODE_VAR_ALT = 2'd3;

    localparam logic [1:0] REG_MODE = 2'd0;
    localparam logic [1:0] REG_KEY_LEN = 2'd1;
    localparam logic [1:0] REG_KEY_LETTERS = 2'd2;

    typedef struct packed {
        logic [3:0] key_pos;
        logic       seen;
    } state_t;

    typedef struct packed {
        logic       is_letter;
        logic       need_space;
        logic [6:0] letter;
    } letter_res_t;

    typedef struct packed {
        logic       last;
        logic [6:0] ch;
    } q_entry_t;

    typedef struct packed {
        logic     push;
        logic     two;
        q_entry_t first;
        q_entry_t second;
    } q_push_t;

endpackage

@@ src/vsc_cipher_core.sv @@
// combinational letter filter, modulo 26 combine and key position update
module vsc_cipher_core #(
    parameter int unsigned MAX_KEY_LEN = 12
) (
    input  logic [7:0]                 char_code,
    input  logic                       start_of_message,
    input  logic [1:0]                 cipher_mode,
    input  logic [3:0]                 key_length,
    input  logic [5*MAX_KEY_LEN-1:0]   key_letters,
    input  vsc_pkg::state_t            state_cur,
    output vsc_pkg::state_t            state_next,
    output vsc_pkg::letter_res_t       res
);
    import vsc_pkg::*;

    localparam int unsigned KIDX_W = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;
    localparam logic [3:0] MAX_LEN = 4'(MAX_KEY_LEN);

    logic [4:0] key_arr [MAX_KEY_LEN];
    logic [7:0] upper;
    logic       is_letter;
    logic [4:0] t_val;
    logic [3:0] len;
    logic [3:0] pos_raw;
    logic [3:0] pos;
    logic       seen;
    logic [4:0] k_raw;
    logic [4:0] k_val;
    logic       variant;
    logic       sub;
    logic [4:0] op_a;
    logic [4:0] op_b;
    logic [5:0] sum;
    logic [4:0] r_val;
    logic [3:0] pos_inc;

    for (genvar i = 0; i < MAX_KEY_LEN; i++)
    begin : g_key
        assign key_arr[i] = key_letters[5*i +: 5];
    end

    always_comb
    begin
        if (char_code >= 8'd97 && char_code <= 8'd122)
        begin
            upper = char_code - 8'd32;
        end
        else
        begin
            upper = char_code;
        end
        is_letter = (upper >= 8'd65) && (upper <= 8'd90);
        t_val = 5'(upper - 8'd65);

        if (key_length == 4'd0)
        begin
            len = 4'd1;
        end
        else if (key_length > MAX_LEN)
        begin
            len = MAX_LEN;
        end
        else
        begin
            len = key_length;
        end

        pos_raw = start_of_message ? 4'd0 : state_cur.key_pos;
        seen = start_of_message ? 1'b0 : state_cur.seen;
        pos = (pos_raw >= len) ? 4'd0 : pos_raw;

        k_raw = key_arr[pos[KIDX_W-1:0]];
        k_val = (k_raw >= 5'(ALPHA_N)) ? k_raw - 5'(ALPHA_N) : k_raw;

        variant = (cipher_mode == MODE_VAR) || (cipher_mode == MODE_VAR_ALT);
        sub = variant || (cipher_mode == MODE_DEC);
        op_a = variant ? k_val : t_val;
        op_b = variant ? t_val : k_val;
        if (sub)
        begin
            sum = {1'b0, op_a} + 6'(ALPHA_N) - {1'b0, op_b};
        end
        else
        begin
            sum = {1'b0, op_a} + {1'b0, op_b};
        end
        r_val = (sum >= 6'(ALPHA_N)) ? 5'(sum - 6'(ALPHA_N)) : sum[4:0];

        res.is_letter = is_letter;
        res.need_space = !variant && seen && (pos == 4'd0);
        res.letter = {2'b00, r_val} + CHAR_A;

        pos_inc = pos + 4'd1;
        if (is_letter)
        begin
            state_next.key_pos = (pos_inc >= len) ? 4'd0 : pos_inc;
            state_next.seen = 1'b1;
        end
        else
        begin
            state_next.key_pos = pos_raw;
            state_next.seen = seen;
        end
    end

endmodule

@@ src/vsc_out_queue.sv @@
// small result queue taking up to two entries and giving one per transfer
module vsc_out_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  vsc_pkg::q_push_t  push_in,
    output logic              room,
    output logic              out_valid,
    input  logic              out_stall,
    output vsc_pkg::q_entry_t out_entry
);
    import vsc_pkg::*;

    q_entry_t             mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_next;
    logic [Q_CNT_W-1:0]   count_reg;
    logic [Q_CNT_W-1:0]   count_next;
    logic [Q_CNT_W-1:0]   push_n;
    logic                 pop;

    assign out_valid = (count_reg != '0);
    assign out_entry = mem[rd_ptr_reg];
    assign room = (count_reg <= Q_CNT_W'(Q_DEPTH - 2));
    assign pop = out_valid && !out_stall;

    always_comb
    begin
        if (!push_in.push)
        begin
            push_n = '0;
        end
        else if (push_in.two)
        begin
            push_n = Q_CNT_W'(2);
        end
        else
        begin
            push_n = Q_CNT_W'(1);
        end
        wr_ptr_next = wr_ptr_reg + Q_PTR_W'(push_n);
        rd_ptr_next = pop ? rd_ptr_reg + Q_PTR_W'(1) : rd_ptr_reg;
        count_next = count_reg + push_n - Q_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_in.push)
        begin
            mem[wr_ptr_reg] <= push_in.first;
            if (push_in.two)
            begin
                mem[wr_ptr_reg + Q_PTR_W'(1)] <= push_in.second;
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= Q_CNT_W'(Q_DEPTH))
        else $error("result queue count above depth");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push_in.push |-> room)
        else $error("push into result queue without room");

endmodule

@@ src/vigenere_stream_cipher.sv @@
// top level of the vigenere stream cipher
// path: input registers, then the result queue, whose head drives the output port
// throughput: one character per cycle while the result queue has room; a character with
//   a group space needs two output transfers, so the output port sets the sustained rate
// reset: asynchronous active low; key position, group flag, queue and config
//   registers are cleared, key_length to 1
module vigenere_stream_cipher #(
    parameter int unsigned MAX_KEY_LEN = 12
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [1:0]               cfg_index,
    input  logic [5*MAX_KEY_LEN-1:0] cfg_wdata,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [7:0]               char_code,
    input  logic                     start_of_message,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [6:0]               out_char,
    output logic                     last_of_run
);
    import vsc_pkg::*;

    localparam int unsigned KEY_W = 5 * MAX_KEY_LEN;

    logic [1:0]       mode_reg;
    logic [1:0]       mode_next;
    logic [3:0]       key_len_reg;
    logic [3:0]       key_len_next;
    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] key_next;

    logic             in_valid_reg;
    logic             in_valid_next;
    logic [7:0]       char_reg;
    logic [7:0]       char_next;
    logic             sof_reg;
    logic             sof_next;

    state_t           state_reg;
    state_t           state_next;
    state_t           core_state;
    letter_res_t      res;
    q_push_t          push;
    q_entry_t         head;
    logic             room;
    logic             advance;

    assign advance = in_valid_reg && room;
    assign in_stall = in_valid_reg && !room;

    vsc_cipher_core #(
        .MAX_KEY_LEN(MAX_KEY_LEN)
    ) u_core (
        .char_code(char_reg),
        .start_of_message(sof_reg),
        .cipher_mode(mode_reg),
        .key_length(key_len_reg),
        .key_letters(key_reg),
        .state_cur(state_reg),
        .state_next(core_state),
        .res(res)
    );

    always_comb
    begin
        push.push = advance && res.is_letter;
        push.two = res.need_space;
        if (res.need_space)
        begin
            push.first = '{last: 1'b0, ch: CHAR_SPACE};
        end
        else
        begin
            push.first = '{last: 1'b1, ch: res.letter};
        end
        push.second = '{last: 1'b1, ch: res.letter};
    end

    vsc_out_queue u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push_in(push),
        .room(room),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_entry(head)
    );

    assign out_char = head.ch;
    assign last_of_run = head.last;

    always_comb
    begin
        mode_next = mode_reg;
        key_len_next = key_len_reg;
        key_next = key_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_MODE:        mode_next = cfg_wdata[1:0];
                REG_KEY_LEN:     key_len_next = cfg_wdata[3:0];
                REG_KEY_LETTERS: key_next = cfg_wdata[KEY_W-1:0];
                default:         mode_next = mode_reg;
            endcase
        end

        if (!in_stall)
        begin
            in_valid_next = in_valid;
            char_next = char_code;
            sof_next = start_of_message;
        end
        else
        begin
            in_valid_next = in_valid_reg;
            char_next = char_reg;
            sof_next = sof_reg;
        end

        state_next = advance ? core_state : state_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_ENC;
            key_len_reg <= 4'd1;
            key_reg <= '0;
            in_valid_reg <= 1'b0;
            state_reg <= '0;
        end
        else
        begin
            mode_reg <= mode_next;
            key_len_reg <= key_len_next;
            key_reg <= key_next;
            in_valid_reg <= in_valid_next;
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        sof_reg <= sof_next;
    end

    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("key state changed without a character moving on");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.key_pos < 4'(MAX_KEY_LEN))
        else $error("key position beyond key storage");

    a_space_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_char == CHAR_SPACE) |-> !last_of_run)
        else $error("space separator marked as last result");

endmodule

@@ test/cipher_checker.sv @@
// checker that predicts the cipher output stream and compares every output transfer
`timescale 1ns / 1ps
module cipher_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [59:0] cfg_wdata,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  char_code,
    input  logic        start_of_message,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [6:0]  out_char,
    input  logic        last_of_run,
    output int          pending,
    output int          errors
);
    import vsc_pkg::*;

    localparam int unsigned KEY_SLOTS = 12;
    localparam logic [7:0] LOWER_A = 8'd97;
    localparam logic [7:0] LOWER_Z = 8'd122;
    localparam logic [7:0] CASE_GAP = 8'd32;

    logic [1:0]  mode;
    logic [3:0]  key_len;
    logic [59:0] key_letters;
    state_t      msg_state;
    q_entry_t    expected_chars[$];
    q_entry_t    head;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
        errors++;
    endtask

    task automatic predict_char(input logic [7:0] code, input logic som);
        int unsigned len;
        int unsigned pos;
        int unsigned t;
        int unsigned k;
        int unsigned r;
        logic [7:0] c;
        logic variant;
        q_entry_t e;
        if (som)
        begin
            msg_state.key_pos = '0;
            msg_state.seen = 1'b0;
        end
        c = code;
        if (c >= LOWER_A && c <= LOWER_Z)
            c = c - CASE_GAP;
        if (c < {1'b0, CHAR_A} || c >= {1'b0, CHAR_A} + ALPHA_N)
            return;
        len = key_len;
        if (len == 0)
            len = 1;
        if (len > KEY_SLOTS)
            len = KEY_SLOTS;
        pos = msg_state.key_pos;
        if (pos >= len)
            pos = 0;
        k = key_letters[5*pos +: 5];
        if (k >= ALPHA_N)
            k = k - ALPHA_N;
        t = c - {1'b0, CHAR_A};
        variant = (mode == MODE_VAR || mode == MODE_VAR_ALT);
        if (variant)
            r = (k + ALPHA_N - t) % ALPHA_N;
        else if (mode == MODE_DEC)
            r = (t + ALPHA_N - k) % ALPHA_N;
        else
            r = (t + k) % ALPHA_N;
        if (!variant && msg_state.seen && pos == 0)
        begin
            e.last = 1'b0;
            e.ch = CHAR_SPACE;
            expected_chars.push_back(e);
        end
        e.last = 1'b1;
        e.ch = CHAR_A + 7'(r);
        expected_chars.push_back(e);
        msg_state.key_pos = (pos + 1 >= len) ? 4'd0 : 4'(pos + 1);
        msg_state.seen = 1'b1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode = MODE_ENC;
            key_len = 4'd1;
            key_letters = '0;
            msg_state = '0;
            expected_chars.delete();
            pending = 0;
            errors = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MODE:        mode = cfg_wdata[1:0];
                    REG_KEY_LEN:     key_len = cfg_wdata[3:0];
                    REG_KEY_LETTERS: key_letters = cfg_wdata;
                    default:         ;
                endcase
            end
            if (in_valid && !in_stall)
                predict_char(char_code, start_of_message);
            if (out_valid && !out_stall)
            begin
                if (expected_chars.size() == 0)
                    report_mismatch("out_char with nothing expected", out_char, 0);
                else
                begin
                    head = expected_chars.pop_front();
                    if (out_char !== head.ch)
                        report_mismatch("out_char", out_char, head.ch);
                    if (last_of_run !== head.last)
                        report_mismatch("last_of_run", last_of_run, head.last);
                end
            end
            pending = expected_chars.size();
        end
    end

endmodule

@@ test/tb_vigenere_stream_cipher.sv @@
// testbench top for the vigenere stream cipher: stimulus, idling and verdict
`timescale 1ns / 1ps
module tb_vigenere_stream_cipher;
    import vsc_pkg::*;

    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int ITEM_TARGET = 1950;
    localparam int PHASE_ITEMS = 150;
    localparam int IDLE_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 4;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [59:0] cfg_wdata;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  char_code;
    logic        start_of_message;
    logic        out_valid;
    logic        out_stall;
    logic [6:0]  out_char;
    logic        last_of_run;
    int          pending;
    int          errors;
    int          items_sent;
    int          idle_cycles;
    bit          quiet;

    vigenere_stream_cipher dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .char_code        (char_code),
        .start_of_message (start_of_message),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .out_char         (out_char),
        .last_of_run      (last_of_run)
    );

    cipher_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .char_code        (char_code),
        .start_of_message (start_of_message),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .out_char         (out_char),
        .last_of_run      (last_of_run),
        .pending          (pending),
        .errors           (errors)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int draw_idle();
        if (quiet)
            return 0;
        return $urandom_range(0, 7);
    endfunction

    function automatic logic [7:0] random_char();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            return 8'd65 + 8'($urandom_range(0, 25));
        if (pick < 85)
            return 8'd97 + 8'($urandom_range(0, 25));
        if (pick < 92)
            return 8'd32;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_char(input logic [7:0] c, input logic som);
        int gap;
        gap = draw_idle();
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        char_code = c;
        start_of_message = som;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(input string s, input bit som_first);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], som_first && i == 0);
    endtask

    task automatic settle();
        in_valid = 1'b0;
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [59:0] value);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic send_message(input bit som_first);
        int len;
        len = $urandom_range(1, 30);
        for (int i = 0; i < len; i++)
            send_char(random_char(), (i == 0) ? som_first : ($urandom_range(0, 19) == 0));
    endtask

    // output side stall
    initial
    begin
        int n;
        out_stall = 1'b0;
        @(negedge clk);
        forever
        begin
            n = draw_idle();
            if (n > 0)
            begin
                out_stall = 1'b1;
                repeat (n) @(negedge clk);
            end
            out_stall = 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        int phase;
        int phase_start;
        int msgs;
        logic [59:0] key;
        logic [3:0] len;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_MODE;
        cfg_wdata = '0;
        in_valid = 1'b0;
        char_code = '0;
        start_of_message = 1'b0;
        quiet = 1'b0;
        items_sent = 0;
        idle_cycles = 0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset config: letter and non-letter boundaries
        send_char(8'h00, 1'b1);
        send_char(8'hff, 1'b0);
        send_text("Az@[`{Za", 1'b0);

        // decrypt, full key with letters above 25
        settle();
        write_reg(REG_MODE, {58'h0, MODE_DEC});
        write_reg(REG_KEY_LEN, 60'd12);
        write_reg(REG_KEY_LETTERS, {5'd25, 5'd31, 5'd26, 5'd0, 5'd13, 5'd7,
                                    5'd1, 5'd30, 5'd24, 5'd2, 5'd28, 5'd25});
        send_text("HELLOWO", 1'b1);

        // key length lowered below the current position, high bits ignored
        settle();
        write_reg(REG_KEY_LEN, {56'hedcba987654321, 4'd3});
        send_text("RLD", 1'b0);

        // odd mode, unused index, zero key length
        settle();
        write_reg(REG_MODE, {58'h3ffffffffffffff, MODE_VAR_ALT});
        write_reg(REG_UNUSED, '1);
        write_reg(REG_KEY_LEN, 60'd0);
        send_char("1", 1'b1);
        send_text("QzM", 1'b0);

        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            settle();
            quiet = ($urandom_range(0, 3) == 0);
            case (phase % 6)
                0: len = 4'd12;
                1: len = 4'd1;
                2: len = 4'd0;
                3: len = 4'd15;
                default: len = 4'($urandom_range(2, 11));
            endcase
            case (phase % 7)
                0: key = '1;
                1: key = '0;
                default: key = 60'({$urandom(), $urandom()});
            endcase
            write_reg(REG_MODE, {58'h0, 2'($urandom_range(0, 3))});
            write_reg(REG_KEY_LEN, {56'h0, len});
            write_reg(REG_KEY_LETTERS, key);
            phase_start = items_sent;
            msgs = 0;
            while (items_sent - phase_start < PHASE_ITEMS)
            begin
                if (phase == 1 && msgs == 3)
                begin
                    in_valid = 1'b0;
                    wait (pending == 0);
                    @(negedge clk);
                end
                if ($urandom_range(0, 9) == 0)
                    send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                else
                    send_message((msgs == 0) ? 1'($urandom_range(0, 1)) : 1'b1);
                msgs++;
            end
            phase++;
        end

        in_valid = 1'b0;
        wait (pending == 0);
        repeat (8) @(negedge clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
